/* hw/rtl/wcds_pkg.sv */
// Shared types, widths and constants for the wind direction/speed converter.
// No dependencies; the RTL files refer to it by scoped names.
package wcds_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 8;
    localparam int TABLE_LEN     = 24;
    localparam int NSTAGES       = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int SHW           = $clog2(TABLE_LEN);

    localparam int W   = 16 + 1 + FRAC_BITS + 2;
    localparam int ZW  = 27;
    localparam int KW  = 24;
    localparam int PW  = (W - 1) + KW;

    localparam logic [KW-1:0] GAIN_Q24 = 24'd10188014;
    localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(180 * 65536);
    localparam logic signed [27:0] DIR_BIAS = 28'(990 * 65536 + 32768);

    typedef struct packed {
        logic signed [W-1:0]  x;
        logic signed [W-1:0]  y;
        logic signed [ZW-1:0] z;
        logic [15:0]          level;
    } cord_t;

    function automatic logic signed [ZW-1:0] atan_val(input logic [SHW-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = ZW'(2949120);
            5'd1:    v = ZW'(1740967);
            5'd2:    v = ZW'(919879);
            5'd3:    v = ZW'(466945);
            5'd4:    v = ZW'(234379);
            5'd5:    v = ZW'(117304);
            5'd6:    v = ZW'(58666);
            5'd7:    v = ZW'(29335);
            5'd8:    v = ZW'(14668);
            5'd9:    v = ZW'(7334);
            5'd10:   v = ZW'(3667);
            5'd11:   v = ZW'(1833);
            5'd12:   v = ZW'(917);
            5'd13:   v = ZW'(458);
            5'd14:   v = ZW'(229);
            5'd15:   v = ZW'(115);
            5'd16:   v = ZW'(57);
            5'd17:   v = ZW'(29);
            5'd18:   v = ZW'(14);
            5'd19:   v = ZW'(7);
            5'd20:   v = ZW'(4);
            5'd21:   v = ZW'(2);
            5'd22:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/wcds_cell.sv */
// One CORDIC vectoring iteration with its own valid/ready pipeline register.
// Depends on wcds_pkg for the datapath struct and the arctangent table.
module wcds_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [wcds_pkg::SHW-1:0]   shift,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  wcds_pkg::cord_t            in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output wcds_pkg::cord_t            out_data
);

    logic                             valid_reg;
    logic                             valid_next;
    wcds_pkg::cord_t                  data_reg;
    wcds_pkg::cord_t                  data_next;
    logic signed [wcds_pkg::W-1:0]    x_in;
    logic signed [wcds_pkg::W-1:0]    y_in;
    logic signed [wcds_pkg::W-1:0]    xs;
    logic signed [wcds_pkg::W-1:0]    ys;
    logic signed [wcds_pkg::ZW-1:0]   ang;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        x_in = in_data.x;
        y_in = in_data.y;
        xs   = x_in >>> shift;
        ys   = y_in >>> shift;
        ang  = wcds_pkg::atan_val(shift);
        data_next       = in_data;
        if (!y_in[wcds_pkg::W-1])
        begin
            data_next.x = x_in + ys;
            data_next.y = y_in - xs;
            data_next.z = in_data.z + ang;
        end
        else
        begin
            data_next.x = x_in - ys;
            data_next.y = y_in + xs;
            data_next.z = in_data.z - ang;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* hw/rtl/wcds_finish.sv */
// Gain compensation, speed rounding, direction wrap and calm check: two stages.
// Depends on wcds_pkg for widths, the gain constant and the datapath struct.
module wcds_finish (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [15:0]      calm_threshold,
    input  logic             in_valid,
    output logic             in_ready,
    input  wcds_pkg::cord_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [8:0]       direction_deg,
    output logic [15:0]      speed,
    output logic [15:0]      level_out
);

    localparam int PW = wcds_pkg::PW;
    localparam int SH = 24 + wcds_pkg::FRAC_BITS;
    localparam logic [PW:0] RND = (PW + 1)'(1) << (23 + wcds_pkg::FRAC_BITS);
    localparam logic [PW:0] SPD_MAX = (PW + 1)'(16'hFFFF);

    logic              a_valid_reg;
    logic              a_valid_next;
    logic              a_ready;
    logic [PW-1:0]     prod_reg;
    logic [PW-1:0]     prod_next;
    logic [8:0]        dir_reg;
    logic [8:0]        dir_next;
    logic [15:0]       lev_reg;

    logic              b_valid_reg;
    logic              b_valid_next;
    logic [8:0]        dir_out_reg;
    logic [8:0]        dir_out_next;
    logic [15:0]       spd_reg;
    logic [15:0]       spd_next;
    logic [15:0]       lev_out_reg;

    logic signed [27:0] dw;
    logic signed [11:0] r;
    logic [PW:0]        sum;
    logic [PW:0]        sh;

    assign a_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || a_ready;

    always_comb
    begin
        prod_next = PW'(in_data.x[wcds_pkg::W-2:0]) * PW'(wcds_pkg::GAIN_Q24);
        dw = wcds_pkg::DIR_BIAS - 28'(in_data.z);
        r  = $signed(dw[27:16]) - 12'sd720;
        if (r > 12'sd360)
        begin
            r = r - 12'sd360;
        end
        else if (r <= 12'sd0)
        begin
            r = r + 12'sd360;
        end
        dir_next     = r[8:0];
        a_valid_next = in_ready ? in_valid : a_valid_reg;

        sum = {1'b0, prod_reg} + RND;
        sh  = sum >> SH;
        spd_next = (sh > SPD_MAX) ? 16'hFFFF : sh[15:0];
        dir_out_next = (spd_next < calm_threshold) ? 9'd0 : dir_reg;
        b_valid_next = a_ready ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_reg <= prod_next;
            dir_reg  <= dir_next;
            lev_reg  <= in_data.level;
        end
        if (a_valid_reg && a_ready)
        begin
            spd_reg     <= spd_next;
            dir_out_reg <= dir_out_next;
            lev_out_reg <= lev_reg;
        end
    end

    assign out_valid     = b_valid_reg;
    assign direction_deg = dir_out_reg;
    assign speed         = spd_reg;
    assign level_out     = lev_out_reg;

endmodule

/* hw/rtl/wind_components_to_direction_speed_unit.sv */
// Wind east/north components to compass direction and speed, top level.
// Uses wcds_pkg, a chain of wcds_cell iterations and wcds_finish.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata: east_speed, north_speed
//   (signed Q8.8) and a level tag. Result words leave on m_tvalid/m_tready/
//   m_tdata: direction_deg, speed (unsigned Q8.8) and level_out.
//   The calm threshold is written on cfg_valid/cfg_ready/cfg_data; cfg_ready
//   is always high, and writes belong to idle periods.
//   Throughput: one word per cycle while m_tready is held high. The chain has
//   1 prep stage, 16 CORDIC cells and 2 finish stages up to m_tvalid.
//   Every stage has its own valid/ready register, so a stalled receiver
//   stops only the stages that are full; empty stages keep filling and
//   s_tready drops once the whole chain holds words.
//   Reset empties the chain and sets the calm threshold to 3.
module wind_components_to_direction_speed_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] east_speed, [31:16] north_speed, [47:32] level
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [8:0] direction_deg, [24:9] speed, [40:25] level_out, rest 0
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int N = wcds_pkg::NSTAGES;
    localparam int W = wcds_pkg::W;

    logic [15:0]       calm_reg;
    logic              p_valid_reg;
    logic              p_valid_next;
    wcds_pkg::cord_t   p_data_reg;
    wcds_pkg::cord_t   p_data_next;

    logic              c_valid [N+1];
    logic              c_ready [N+1];
    wcds_pkg::cord_t   c_data  [N+1];

    logic signed [16:0] ex;
    logic signed [16:0] ny;
    logic [8:0]         dir_w;
    logic [15:0]        spd_w;
    logic [15:0]        lev_w;

    assign cfg_ready = 1'b1;
    assign s_tready  = !p_valid_reg || c_ready[0];

    always_comb
    begin
        ex = 17'($signed(s_tdata[15:0]));
        ny = 17'($signed(s_tdata[31:16]));
        p_data_next.z = '0;
        if (ex[16])
        begin
            ex = -ex;
            ny = -ny;
            p_data_next.z = wcds_pkg::Z_HALF_TURN;
        end
        p_data_next.x     = W'(ex) <<< wcds_pkg::FRAC_BITS;
        p_data_next.y     = W'(ny) <<< wcds_pkg::FRAC_BITS;
        p_data_next.level = s_tdata[47:32];
        p_valid_next = s_tready ? s_tvalid : p_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calm_reg    <= 16'd3;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                calm_reg <= cfg_data;
            end
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            p_data_reg <= p_data_next;
        end
    end

    assign c_valid[0] = p_valid_reg;
    assign c_data[0]  = p_data_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        wcds_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (wcds_pkg::SHW'(i)),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .in_data   (c_data[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .out_data  (c_data[i+1])
        );
    end

    wcds_finish u_finish (
        .clk            (clk),
        .rst_n          (rst_n),
        .calm_threshold (calm_reg),
        .in_valid       (c_valid[N]),
        .in_ready       (c_ready[N]),
        .in_data        (c_data[N]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .direction_deg  (dir_w),
        .speed          (spd_w),
        .level_out      (lev_w)
    );

    assign m_tdata = {7'd0, lev_w, spd_w, dir_w};

endmodule

/* test/wind_direction_speed_checker.sv */
// Checker for the wind direction/speed unit: watches the input, result and
// calm-threshold channels, predicts each result and compares it field by field.
// Depends on nothing but the port-level channels of the block.
module wind_direction_speed_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] east_speed, [31:16] north_speed, [47:32] level
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [8:0] direction_deg, [24:9] speed, [40:25] level_out
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);

    localparam int     CORDIC_ITER = 16;
    localparam longint GAIN_Q24    = 10188014;
    localparam longint DEG_UNIT    = 65536;
    localparam longint ATAN_STEP [CORDIC_ITER] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic [8:0]  direction;
        logic [15:0] speed;
        logic [15:0] level;
    } wind_polar_t;

    wind_polar_t expected_polar[$];
    logic [15:0] calm_level;

    function automatic wind_polar_t predict_polar(input logic [15:0] east,
                                                  input logic [15:0] north,
                                                  input logic [15:0] level,
                                                  input logic [15:0] calm);
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        longint      prod;
        longint      spd;
        longint      d;
        longint      r;
        wind_polar_t res;
        x = longint'($signed(east));
        y = longint'($signed(north));
        z = 0;
        // fold the left half-plane onto the right one
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 180 * DEG_UNIT;
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < CORDIC_ITER; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
        end
        prod = x * GAIN_Q24;
        spd  = (prod + (longint'(1) <<< 31)) >>> 32;
        if (spd > 65535)
            spd = 65535;
        d = 990 * DEG_UNIT + DEG_UNIT / 2 - z;
        if (d < 0)
            d = 0;
        r = (d >>> 16) - 720;
        while (r > 360)
            r = r - 360;
        while (r <= 0)
            r = r + 360;
        if (spd < longint'(calm))
            r = 0;
        res.direction = r[8:0];
        res.speed     = spd[15:0];
        res.level     = level;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        wind_polar_t want;
        wind_polar_t got;
        int          errs;
        errs = 0;
        if (!rst_n)
        begin
            calm_level = 16'd3;
            expected_polar.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            // check results before queuing new words
            if (m_tvalid && m_tready)
            begin
                got.direction = m_tdata[8:0];
                got.speed     = m_tdata[24:9];
                got.level     = m_tdata[40:25];
                if (expected_polar.size() == 0)
                begin
                    $display("%0t unexpected result word: direction %0d speed %0d level %0d",
                             $time, got.direction, got.speed, got.level);
                    errs++;
                end
                else
                begin
                    want = expected_polar.pop_front();
                    if (got.direction !== want.direction)
                    begin
                        $display("%0t direction_deg mismatch: expected %0d, actual %0d",
                                 $time, want.direction, got.direction);
                        errs++;
                    end
                    if (got.speed !== want.speed)
                    begin
                        $display("%0t speed mismatch: expected %0d, actual %0d",
                                 $time, want.speed, got.speed);
                        errs++;
                    end
                    if (got.level !== want.level)
                    begin
                        $display("%0t level_out mismatch: expected %0d, actual %0d",
                                 $time, want.level, got.level);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_polar.push_back(predict_polar(s_tdata[15:0], s_tdata[31:16],
                                                       s_tdata[47:32], calm_level));
            if (cfg_valid && cfg_ready)
                calm_level = cfg_data;
            fail_count    <= fail_count + errs;
            pending_count <= expected_polar.size();
        end
    end

endmodule

/* test/wind_components_to_direction_speed_unit_test.sv */
// Top of the wind direction/speed testbench: clock, reset, stimulus, receiver
// stalls and verdict. Depends on the block and wind_direction_speed_checker.
module wind_components_to_direction_speed_unit_test;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 160;
    localparam int DRAIN_CYCLES    = 40;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [47:0] s_tdata    = '0;
    logic        m_tready   = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [15:0] cfg_data   = '0;
    logic        hold_off_req = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [47:0] m_tdata;
    wire         cfg_ready;
    int          fail_count;
    int          pending_count;
    int          burst_left  = 0;
    int          cycle_count = 0;
    bit          hold_off_done = 1'b0;

    wind_components_to_direction_speed_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    wind_direction_speed_checker polar_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("wind_components_to_direction_speed_unit verification failed");
            $finish;
        end
    end

    // receiver: stretches of differing stall behavior, plus one long hold-off
    initial
    begin : receiver
        int stretch;
        int mode;
        wait (rst_n);
        forever
        begin
            stretch = $urandom_range(8, 64);
            mode    = $urandom_range(0, 3);
            repeat (stretch)
            begin
                @(posedge clk);
                if (hold_off_req && !hold_off_done)
                begin
                    m_tready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                    hold_off_done = 1'b1;
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 9) != 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    task automatic send_word(input logic [15:0] east, input logic [15:0] north,
                             input logic [15:0] level);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {level, north, east};
        do @(posedge clk); while (!s_tready);
    endtask

    // drain the pipeline, then load a new calm threshold
    task automatic write_calm(input logic [15:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] random_component();
        case ($urandom_range(0, 5))
            0, 1: return 16'($urandom);
            2:    return 16'($urandom_range(0, 32)) - 16'd16;
            3:    return 16'($urandom_range(0, 4)) - 16'd2;
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            default: return 16'($urandom_range(0, 8192)) - 16'd4096;
        endcase
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_word(random_component(), random_component(), 16'($urandom));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // axes, diagonals, extremes, calm edge and the wrap around north
        send_word(16'h0000, 16'h0000, 16'h0000);
        send_word(16'h7FFF, 16'h0000, 16'hFFFF);
        send_word(16'h8000, 16'h0000, 16'h1234);
        send_word(16'h0000, 16'h7FFF, 16'h8001);
        send_word(16'h0000, 16'h8000, 16'h7FFE);
        send_word(16'h7FFF, 16'h7FFF, 16'h0001);
        send_word(16'h8000, 16'h8000, 16'hFFFE);
        send_word(16'h8000, 16'h7FFF, 16'h00FF);
        send_word(16'h7FFF, 16'h8000, 16'hFF00);
        send_word(16'hFFFF, 16'h0000, 16'h0F0F);
        send_word(16'h0003, 16'h0000, 16'hF0F0);
        send_word(16'h0002, 16'h0000, 16'h3333);
        send_word(16'h0000, 16'hFFFD, 16'hCCCC);
        send_word(16'h0100, 16'h0100, 16'h0002);
        send_word(16'hFF00, 16'h0100, 16'h0004);
        send_word(16'h0100, 16'hFF00, 16'h0008);
        send_word(16'hFF00, 16'hFF00, 16'h0010);
        send_word(16'h0100, 16'h0001, 16'h0020);
        send_word(16'hFF00, 16'h0001, 16'h0040);
        send_word(16'h0001, 16'hFF00, 16'h0080);
        send_word(16'hFFFF, 16'hFF00, 16'h0100);

        write_calm(16'd0);
        send_word(16'h0000, 16'h0000, 16'h5555);
        send_word(16'h0001, 16'h0000, 16'hAAAA);
        send_random(60);
        hold_off_req <= 1'b1;
        send_random(140);

        write_calm(16'hFFFF);
        send_random(120);

        write_calm(16'($urandom_range(1, 1024)));
        send_random(200);

        write_calm(16'd46341);
        send_random(100);

        write_calm(16'd3);
        send_random(200);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("wind_components_to_direction_speed_unit verification clean");
        else
            $display("wind_components_to_direction_speed_unit verification failed");
        $finish;
    end

endmodule

/* wind_components_to_direction_speed_unit.f */
hw/rtl/wcds_pkg.sv
hw/rtl/wcds_cell.sv
hw/rtl/wcds_finish.sv
hw/rtl/wind_components_to_direction_speed_unit.sv
test/wind_direction_speed_checker.sv
test/wind_components_to_direction_speed_unit_test.sv
